// ===== sv/cas_pkg.sv =====
`timescale 1ns / 1ps

package cas_pkg;

	localparam int MIN_PER_DAY  = 1440;
	localparam int MIN_PER_HOUR = 60;
	localparam int READING_DIV  = 10;
	// n*205 >> 11 equals n/10 for every n below 1029
	localparam int DIV10_MUL    = 205;
	localparam int DIV10_SHIFT  = 11;

	localparam int MIN_W      = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_LOW    = 3'd0,
		REG_TEMP_HIGH   = 3'd1,
		REG_HUMID_LOW   = 3'd2,
		REG_HUMID_HIGH  = 3'd3,
		REG_FAN_ACTIVE  = 3'd4,
		REG_FAN_PERIOD  = 3'd5,
		REG_LIGHT_START = 3'd6,
		REG_LIGHT_STOP  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [10:0] temp_tenths;
		logic [9:0]         humid_tenths;
		logic [4:0]         hour_now;
		logic [5:0]         minute_now;
		logic               run_cycle;
		logic               light_allowed;
	} cas_tick_t;

	typedef struct packed {
		logic             heater_drive;
		logic             fogger_drive;
		logic             fan_drive;
		logic             light_drive;
		logic [MIN_W-1:0] next_fan_start;
	} cas_result_t;

	// fold a value below two days into one day
	function automatic logic [MIN_W-1:0] mod_day(input logic [MIN_W:0] v);
		logic [MIN_W:0] diff;
		diff = v - (MIN_W+1)'(MIN_PER_DAY);
		if (v >= (MIN_W+1)'(MIN_PER_DAY)) begin
			return diff[MIN_W-1:0];
		end
		return v[MIN_W-1:0];
	endfunction

	// divide by ten, valid for magnitudes up to 1028
	function automatic logic [6:0] div10(input logic [10:0] mag);
		logic [18:0] prod;
		prod = mag * 19'(DIV10_MUL);
		return prod[DIV10_SHIFT+6:DIV10_SHIFT];
	endfunction

endpackage

// ===== sv/cas_ifs.sv =====
`timescale 1ns / 1ps

interface cas_tick_if;
	import cas_pkg::*;
	logic      valid;
	logic      ready;
	cas_tick_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cas_result_if;
	import cas_pkg::*;
	logic        valid;
	logic        ready;
	cas_result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cas_cfg_if;
	import cas_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== sv/climate_actuator_scheduler.sv =====
`timescale 1ns / 1ps

// Climate actuator scheduler. Each tick beat (temperature and humidity in tenths,
// hour and minute, run flag, light enable) produces exactly one result beat with the
// heater, fogger, fan and light drives and the start minute of the current fan window.
// A tick is registered on entry, evaluated there against the actuator state and
// written to the result register once it is free; a new tick is accepted every
// cycle unless a result is stalled, and a tick still waits in the entry register
// while a finished result is held by the sink. Throughput is one tick per cycle when
// unstalled, set by the state update loop. Configuration writes are always ready and
// take effect on the next tick; write them only while no tick is in flight.
module climate_actuator_scheduler (
	input  logic clk,
	input  logic arst_n,
	cas_tick_if.sink     tick,
	cas_result_if.source result,
	cas_cfg_if.sink      cfg
);
	import cas_pkg::*;

	// configuration
	logic signed [7:0] temp_low_q, temp_high_q;
	logic [6:0]        humid_low_q, humid_high_q;
	logic [MIN_W-1:0]  act_mod_q, per_mod_q;
	logic [4:0]        light_start_q, light_stop_q;

	// actuator and window state
	logic             heater_q, fogger_q, fan_q, light_q, loaded_q;
	logic [MIN_W-1:0] start_q, stop_q;

	// pipeline
	cas_tick_t   tick_s1;
	logic        v_s1;
	cas_result_t res_q;
	logic        res_valid_q;
	logic        advance;
	logic        fire;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_low_q    <= 8'sd18;
			temp_high_q   <= 8'sd24;
			humid_low_q   <= 7'd80;
			humid_high_q  <= 7'd90;
			act_mod_q     <= MIN_W'(15);
			per_mod_q     <= MIN_W'(60);
			light_start_q <= 5'd8;
			light_stop_q  <= 5'd20;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_TEMP_LOW:    temp_low_q    <= cfg.data[7:0];
				REG_TEMP_HIGH:   temp_high_q   <= cfg.data[7:0];
				REG_HUMID_LOW:   humid_low_q   <= cfg.data[6:0];
				REG_HUMID_HIGH:  humid_high_q  <= cfg.data[6:0];
				REG_FAN_ACTIVE:  act_mod_q     <= mod_day({1'b0, cfg.data});
				REG_FAN_PERIOD:  per_mod_q     <= mod_day({1'b0, cfg.data});
				REG_LIGHT_START: light_start_q <= cfg.data[4:0];
				REG_LIGHT_STOP:  light_stop_q  <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

	assign advance    = !res_valid_q || result.ready;
	assign tick.ready = !v_s1 || advance;
	assign fire       = v_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (tick.ready) begin
			v_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1 <= tick.data;
		end
	end

	// readings in whole units, truncated toward zero
	logic [10:0]       temp_mag;
	logic [6:0]        temp_quo, humid_deg;
	logic signed [7:0] temp_deg;
	logic [MIN_W:0]    clock_min;
	logic [MIN_W-1:0]  now_min;

	always_comb begin
		temp_mag  = tick_s1.temp_tenths[10] ? 11'(-tick_s1.temp_tenths)
		                                    : 11'(tick_s1.temp_tenths);
		temp_quo  = div10(temp_mag);
		temp_deg  = tick_s1.temp_tenths[10] ? -$signed({1'b0, temp_quo})
		                                    : $signed({1'b0, temp_quo});
		humid_deg = div10({1'b0, tick_s1.humid_tenths});
		// hour*60 as hour*64 - hour*4
		clock_min = {1'b0, tick_s1.hour_now, 6'b0} - {5'b0, tick_s1.hour_now, 2'b0}
		          + {6'b0, tick_s1.minute_now};
		now_min   = mod_day(clock_min);
	end

	// fan window: first tick loads it from the current minute
	logic [MIN_W-1:0] win_start, win_stop, adv_start, adv_stop;
	logic             in_win;

	always_comb begin
		win_start = loaded_q ? start_q : now_min;
		win_stop  = loaded_q ? stop_q : mod_day({1'b0, now_min} + {1'b0, act_mod_q});
		if (win_start == win_stop) begin
			in_win = 1'b0;
		end else if (win_start < win_stop) begin
			in_win = (now_min >= win_start) && (now_min < win_stop);
		end else begin
			in_win = (now_min >= win_start) || (now_min < win_stop);
		end
		adv_start = mod_day({1'b0, win_start} + {1'b0, per_mod_q});
		adv_stop  = mod_day({1'b0, adv_start} + {1'b0, act_mod_q});
	end

	logic             heater_n, fogger_n, fan_n, light_n, lit;
	logic [MIN_W-1:0] start_n, stop_n;

	always_comb begin
		heater_n = 1'b0;
		fogger_n = 1'b0;
		fan_n    = 1'b0;
		light_n  = 1'b0;
		start_n  = win_start;
		stop_n   = win_stop;
		lit      = (tick_s1.hour_now >= light_start_q) && (tick_s1.hour_now < light_stop_q);
		if (tick_s1.run_cycle) begin
			heater_n = heater_q;
			if (temp_deg <= temp_low_q && !heater_q) begin
				heater_n = 1'b1;
			end else if (temp_deg >= temp_high_q && heater_q) begin
				heater_n = 1'b0;
			end
			fogger_n = fogger_q;
			if (humid_deg < humid_low_q && !fogger_q) begin
				fogger_n = 1'b1;
			end else if (humid_deg > humid_high_q && fogger_q) begin
				fogger_n = 1'b0;
			end
			fan_n = fan_q;
			if (in_win && !fan_q) begin
				fan_n = 1'b1;
			end else if (!in_win && fan_q) begin
				fan_n   = 1'b0;
				start_n = adv_start;
				stop_n  = adv_stop;
			end
			light_n = tick_s1.light_allowed && lit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heater_q    <= 1'b0;
			fogger_q    <= 1'b0;
			fan_q       <= 1'b0;
			light_q     <= 1'b0;
			loaded_q    <= 1'b0;
			start_q     <= '0;
			stop_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				res_valid_q <= v_s1;
			end
			if (fire) begin
				heater_q <= heater_n;
				fogger_q <= fogger_n;
				fan_q    <= fan_n;
				light_q  <= light_n;
				loaded_q <= 1'b1;
				start_q  <= start_n;
				stop_q   <= stop_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.heater_drive   <= heater_n;
			res_q.fogger_drive   <= fogger_n;
			res_q.fan_drive      <= fan_n;
			res_q.light_drive    <= light_n;
			res_q.next_fan_start <= start_n;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

// ===== sv/cas_checker.sv =====
`timescale 1ns / 1ps

module cas_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 tick_valid,
	input logic                 tick_ready,
	input logic                 result_valid,
	input logic                 result_ready,
	input cas_pkg::cas_result_t result_data
);
	import cas_pkg::*;

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result beat changed while stalled");

	// window start is always a minute of the day
	a_start_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_data.next_fan_start < MIN_W'(MIN_PER_DAY))
		else $error("fan window start out of range");

	// ticks back up only behind a stalled result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_ready |-> result_valid && !result_ready)
		else $error("tick refused without output stall");

	// a fresh result comes from a tick accepted into the entry register and passed to the result register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(tick_valid && tick_ready, 2))
		else $error("result appeared without a tick");

endmodule

bind climate_actuator_scheduler cas_checker u_cas_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_valid   (tick.valid),
	.tick_ready   (tick.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import cas_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cas_tick_if   tick_ch();
	cas_result_if res_ch();
	cas_cfg_if    cfg_ch();

	climate_actuator_scheduler u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (tick_ch),
		.result(res_ch),
		.cfg   (cfg_ch)
	);

	always #5 clk = ~clk;

	// shadow of the setpoint registers
	logic signed [7:0] t_lo     = 8'sd18;
	logic signed [7:0] t_hi     = 8'sd24;
	logic [6:0]        h_lo     = 7'd80;
	logic [6:0]        h_hi     = 7'd90;
	logic [10:0]       fan_act  = 11'd15;
	logic [10:0]       fan_per  = 11'd60;
	logic [4:0]        lt_start = 5'd8;
	logic [4:0]        lt_stop  = 5'd20;

	// predicted actuator and window state
	logic heat_on    = 1'b0;
	logic fog_on     = 1'b0;
	logic fan_on     = 1'b0;
	logic lamp_on    = 1'b0;
	logic win_loaded = 1'b0;
	int   win_start  = 0;
	int   win_stop   = 0;

	cas_result_t expected_drives[$];
	int err_count     = 0;
	int cycle_count   = 0;
	int src_gap_pct   = 0;
	int sink_stall_pct = 0;
	int hold_cycles   = 0;
	int sim_min       = 0;

	function automatic int stop_after(input int start);
		return (start + int'(fan_act) % MIN_PER_DAY) % MIN_PER_DAY;
	endfunction

	function automatic logic win_covers(input int now);
		if (win_start == win_stop)
			return 1'b0;
		if (win_start < win_stop)
			return now >= win_start && now < win_stop;
		return now >= win_start || now < win_stop;
	endfunction

	function automatic cas_result_t climate_step(input cas_tick_t t);
		int deg;
		int pct;
		int now;
		int per;
		logic in_win;
		cas_result_t r;
		deg = $signed(t.temp_tenths) / READING_DIV;
		pct = int'(t.humid_tenths) / READING_DIV;
		now = (int'(t.hour_now) * MIN_PER_HOUR + int'(t.minute_now)) % MIN_PER_DAY;
		if (!win_loaded) begin
			win_loaded = 1'b1;
			win_start = now;
			win_stop = stop_after(now);
		end
		if (t.run_cycle) begin
			if (deg <= int'(t_lo) && !heat_on)
				heat_on = 1'b1;
			else if (deg >= int'(t_hi) && heat_on)
				heat_on = 1'b0;
			if (pct < int'(h_lo) && !fog_on)
				fog_on = 1'b1;
			else if (pct > int'(h_hi) && fog_on)
				fog_on = 1'b0;
			in_win = win_covers(now);
			if (in_win && !fan_on) begin
				fan_on = 1'b1;
			end else if (!in_win && fan_on) begin
				per = int'(fan_per) % MIN_PER_DAY;
				fan_on = 1'b0;
				win_start = (win_start + per) % MIN_PER_DAY;
				win_stop = stop_after(win_start);
			end
			if (t.light_allowed)
				lamp_on = t.hour_now >= lt_start && t.hour_now < lt_stop;
			else
				lamp_on = 1'b0;
		end else begin
			heat_on = 1'b0;
			fog_on = 1'b0;
			fan_on = 1'b0;
			lamp_on = 1'b0;
		end
		r.heater_drive = heat_on;
		r.fogger_drive = fog_on;
		r.fan_drive = fan_on;
		r.light_drive = lamp_on;
		r.next_fan_start = MIN_W'(win_start);
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic cas_tick_t tick_at(input int temp, input int humid, input int hour,
			input int minute, input logic run, input logic allowed);
		cas_tick_t t;
		t.temp_tenths = 11'(temp);
		t.humid_tenths = 10'(humid);
		t.hour_now = 5'(hour);
		t.minute_now = 6'(minute);
		t.run_cycle = run;
		t.light_allowed = allowed;
		return t;
	endfunction

	function automatic cas_tick_t tick_at_minute(input int mod);
		return tick_at($urandom_range(0, 1200) - 400, $urandom_range(1000),
			mod / MIN_PER_HOUR, mod % MIN_PER_HOUR, 1'b1, 1'b1);
	endfunction

	// day time walks forward so the fan windows get visited; some beats are raw noise
	function automatic cas_tick_t random_tick();
		cas_tick_t t;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		t = raw[$bits(cas_tick_t)-1:0];
		if ($urandom_range(9) != 0) begin
			if ($urandom_range(19) == 0)
				sim_min = (sim_min + $urandom_range(0, 700)) % MIN_PER_DAY;
			else
				sim_min = (sim_min + $urandom_range(0, 25)) % MIN_PER_DAY;
			t = tick_at($urandom_range(0, 1200) - 400, $urandom_range(1000),
				sim_min / MIN_PER_HOUR, sim_min % MIN_PER_HOUR,
				$urandom_range(19) != 0, $urandom_range(4) != 0);
		end
		return t;
	endfunction

	task automatic send_tick(input cas_tick_t t);
		int gap;
		@(negedge clk);
		if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
			gap = gap_len();
			tick_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_ch.data = t;
		tick_ch.valid = 1'b1;
		do @(posedge clk); while (!tick_ch.ready);
		expected_drives.push_back(climate_step(t));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		tick_ch.valid = 1'b0;
		while (expected_drives.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		wait_drained();
		cfg_ch.index = idx;
		cfg_ch.data = val;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_TEMP_LOW:    t_lo = val[7:0];
			REG_TEMP_HIGH:   t_hi = val[7:0];
			REG_HUMID_LOW:   h_lo = val[6:0];
			REG_HUMID_HIGH:  h_hi = val[6:0];
			REG_FAN_ACTIVE:  fan_act = val;
			REG_FAN_PERIOD:  fan_per = val;
			REG_LIGHT_START: lt_start = val[4:0];
			REG_LIGHT_STOP:  lt_stop = val[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic write_all(input int tl, input int th, input int hl, input int hh,
			input int act, input int per, input int ls, input int le);
		write_reg(REG_TEMP_LOW, CFG_DATA_W'(tl));
		write_reg(REG_TEMP_HIGH, CFG_DATA_W'(th));
		write_reg(REG_HUMID_LOW, CFG_DATA_W'(hl));
		write_reg(REG_HUMID_HIGH, CFG_DATA_W'(hh));
		write_reg(REG_FAN_ACTIVE, CFG_DATA_W'(act));
		write_reg(REG_FAN_PERIOD, CFG_DATA_W'(per));
		write_reg(REG_LIGHT_START, CFG_DATA_W'(ls));
		write_reg(REG_LIGHT_STOP, CFG_DATA_W'(le));
	endtask

	// first beat loads the window even with the run flag clear; 23:59 gives a window
	// that wraps past midnight
	task automatic test_first_tick();
		send_tick(tick_at(200, 500, 23, 59, 1'b0, 1'b1));
		send_tick(tick_at(100, 700, 0, 5, 1'b1, 1'b1));
		send_tick(tick_at(300, 950, 0, 20, 1'b1, 1'b1));
		send_tick(tick_at(250, 850, 0, 59, 1'b1, 1'b0));
		sim_min = 60;
	endtask

	task automatic test_field_extremes();
		send_tick(tick_at(-1024, 0, 0, 0, 1'b1, 1'b1));
		send_tick(tick_at(1023, 1023, 31, 63, 1'b1, 1'b1));
		send_tick(tick_at(-400, 1000, 23, 59, 1'b1, 1'b1));
		send_tick(tick_at(800, 0, 24, 0, 1'b1, 1'b1));
		send_tick(tick_at(-19, 799, 8, 0, 1'b1, 1'b1));
		send_tick(tick_at(-1, 801, 19, 59, 1'b1, 1'b1));
		send_tick(tick_at(180, 800, 20, 0, 1'b1, 1'b1));
		send_tick(tick_at(240, 901, 12, 30, 1'b1, 1'b0));
		send_tick(tick_at(-1024, 0, 12, 30, 1'b0, 1'b1));
		send_tick(tick_at(0, 512, 16, 32, 1'b1, 1'b1));
	endtask

	// crossed hysteresis bands, light limits beyond the day, register extremes
	task automatic test_bands_and_light();
		write_all(30, 10, 95, 20, 15, 60, 0, 24);
		send_tick(tick_at(250, 500, 23, 10, 1'b1, 1'b1));
		send_tick(tick_at(350, 990, 24, 0, 1'b1, 1'b1));
		send_tick(tick_at(50, 100, 31, 0, 1'b1, 1'b1));
		write_all(-128, 127, 127, 127, 15, 60, 22, 6);
		send_tick(tick_at(-1024, 1023, 23, 0, 1'b1, 1'b1));
		send_tick(tick_at(1023, 0, 3, 0, 1'b1, 1'b1));
		write_all(127, -128, 0, 0, 15, 60, 31, 31);
		send_tick(tick_at(0, 0, 31, 0, 1'b1, 1'b1));
		send_tick(tick_at(1023, 1023, 12, 0, 1'b1, 1'b1));
		write_all(18, 24, 80, 90, 15, 60, 8, 20);
	endtask

	task automatic test_backpressure();
		int n;
		wait_drained();
		src_gap_pct = 0;
		hold_cycles = 80;
		for (n = 0; n < 20; n++)
			send_tick(random_tick());
	endtask

	task automatic random_phase(input int count, input int src_pct, input int sink_pct);
		int n;
		src_gap_pct = src_pct;
		sink_stall_pct = sink_pct;
		for (n = 0; n < count; n++)
			send_tick(random_tick());
		wait_drained();
	endtask

	task automatic test_random();
		int act;
		write_all($urandom_range(0, 60) - 20, $urandom_range(10, 60), $urandom_range(100),
			$urandom_range(100), $urandom_range(5, 40), $urandom_range(20, 90),
			$urandom_range(23), $urandom_range(24));
		random_phase(100, 0, 0);
		write_all($urandom_range(0, 120) - 40, $urandom_range(0, 120) - 40,
			$urandom_range(100), $urandom_range(100), $urandom_range(1, 120),
			$urandom_range(1, 240), $urandom_range(23), $urandom_range(24));
		random_phase(100, 30, 30);
		// raw register bits; an active time that folds to zero would freeze the fan
		do act = $urandom_range(2047); while (act % MIN_PER_DAY == 0);
		write_all($urandom_range(255), $urandom_range(255), $urandom_range(127),
			$urandom_range(127), act, $urandom_range(2047), $urandom_range(31),
			$urandom_range(31));
		random_phase(100, 50, 50);
		write_all(2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047);
		random_phase(80, 10, 60);
		write_all(0, 0, 0, 0, 1, 0, 0, 0);
		random_phase(80, 60, 10);
		write_all($urandom_range(0, 120) - 40, $urandom_range(0, 120) - 40,
			$urandom_range(100), $urandom_range(100), 1439, 1439,
			$urandom_range(23), $urandom_range(24));
		random_phase(100, 20, 20);
	endtask

	// zero period keeps the window in place; a zero active time empties it for good,
	// so this runs last
	task automatic test_window_edges();
		write_reg(REG_FAN_ACTIVE, 11'd30);
		write_reg(REG_FAN_PERIOD, 11'd0);
		send_tick(tick_at_minute(win_start));
		send_tick(tick_at_minute(win_stop));
		send_tick(tick_at_minute(win_start));
		send_tick(tick_at_minute(win_stop));
		write_reg(REG_FAN_PERIOD, 11'd45);
		send_tick(tick_at_minute(win_start));
		write_reg(REG_FAN_ACTIVE, 11'd1440);
		send_tick(tick_at_minute(win_stop));
		send_tick(tick_at_minute(win_start));
		write_reg(REG_FAN_ACTIVE, 11'd0);
		random_phase(30, 20, 20);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic check_field(input string name, input logic [10:0] want,
			input logic [10:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		cas_result_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (expected_drives.size() == 0) begin
				$error("result beat with nothing expected");
				err_count++;
			end else begin
				want = expected_drives.pop_front();
				check_field("heater_drive", 11'(want.heater_drive),
					11'(res_ch.data.heater_drive));
				check_field("fogger_drive", 11'(want.fogger_drive),
					11'(res_ch.data.fogger_drive));
				check_field("fan_drive", 11'(want.fan_drive), 11'(res_ch.data.fan_drive));
				check_field("light_drive", 11'(want.light_drive),
					11'(res_ch.data.light_drive));
				check_field("next_fan_start", want.next_fan_start,
					res_ch.data.next_fan_start);
			end
		end
	end

	// result side ready: forced hold-off first, then random stalls
	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res_ch.ready = 1'b0;
				hold_cycles--;
			end else if (stall_left > 0) begin
				res_ch.ready = 1'b0;
				stall_left--;
			end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
				res_ch.ready = 1'b0;
				stall_left = gap_len() - 1;
			end else begin
				res_ch.ready = 1'b1;
			end
		end
	end

	initial begin
		tick_ch.valid = 1'b0;
		tick_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_TEMP_LOW;
		cfg_ch.data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		sink_stall_pct = 20;
		src_gap_pct = 20;
		test_first_tick();
		test_field_extremes();
		test_bands_and_light();
		test_backpressure();
		test_random();
		test_window_edges();
		wait_drained();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== climate_actuator_scheduler.f =====
sv/cas_pkg.sv
sv/cas_ifs.sv
sv/climate_actuator_scheduler.sv
sv/cas_checker.sv
tb/tb.sv
